[hdl/assert_macros.svh]
// assertion macros shared by the keep-alive header parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define KAH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define KAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/kah_pkg.sv]
// types, constants and helper functions of the keep-alive header parser
package kah_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int OUT_BITS       = 31;
  localparam int BYTE_BITS      = 8;
  localparam int KW_POS_BITS    = 3;

  localparam logic [KW_POS_BITS-1:0] KW_TO_LAST  = 3'd6;
  localparam logic [KW_POS_BITS-1:0] KW_MAX_LAST = 3'd2;

  localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_BITS-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_SKIP_WS,
    PH_MATCH_TO,
    PH_MATCH_MAX,
    PH_EQ_TO,
    PH_EQ_MAX,
    PH_DIGITS_TO,
    PH_DIGITS_MAX,
    PH_SKIP_COMMA
  } phase_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] header_byte;
    logic                 final_byte;
  } in_item_t;

  // first member lands in the top bits
  typedef struct packed {
    logic [OUT_BITS-1:0] max_value;
    logic                max_found;
    logic [OUT_BITS-1:0] timeout_value;
    logic                timeout_found;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

  function automatic logic [BYTE_BITS-1:0] kw_to_char(input logic [KW_POS_BITS-1:0] pos);
    logic [BYTE_BITS-1:0] c;
    case (pos)
      3'd0:    c = 8'h74;  // t
      3'd1:    c = 8'h69;  // i
      3'd2:    c = 8'h6D;  // m
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h6F;  // o
      3'd5:    c = 8'h75;  // u
      3'd6:    c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_BITS-1:0] kw_max_char(input logic [KW_POS_BITS-1:0] pos);
    logic [BYTE_BITS-1:0] c;
    case (pos)
      3'd0:    c = 8'h6D;  // m
      3'd1:    c = 8'h61;  // a
      3'd2:    c = 8'h78;  // x
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [BYTE_BITS-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

[hdl/keep_alive_header_parser.sv]
// keep-alive header parser: top level with result register
//
// slave stream carries the header value one byte per request in tdata,
// with tlast on the final byte. master stream carries one result request
// per header, issued on its final byte: both parsed values and found flags.
// a byte is registered on acceptance and parsed from the input register;
// if it is final, the result is registered into the output register as
// the parser steps. one byte is taken per cycle unless the receiver stalls;
// the parse state updates each step via a single times-ten-plus-digit unit.
// non-final bytes produce nothing on the master side.
// when the receiver stalls a pending result holds, the parser stops and
// the input register fills, after which tready drops until the result
// is taken. reset clears the parse state, both found flags and values,
// and empties both registers; no clearing pass is needed.
`include "assert_macros.svh"

module keep_alive_header_parser #(
  parameter int VALUE_BITS = kah_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // header_byte
  input  logic                            s_axis_tlast,  // final_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // max_value[30:0], max_found, timeout_value[30:0], timeout_found
  output logic [kah_pkg::RESULT_BITS-1:0] m_axis_tdata
);
  import kah_pkg::*;

  logic     advance, step, item_valid, result_valid;
  in_item_t item;
  result_t  result, out_data;
  logic     out_valid;
  logic     to_clean, max_clean;

  assign advance = !out_valid || m_axis_tready;
  assign step    = item_valid && advance;

  kah_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  kah_parser #(
    .VALUE_BITS (VALUE_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result_valid) begin
      out_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign to_clean  = out_data.timeout_found || (out_data.timeout_value == '0);
  assign max_clean = out_data.max_found || (out_data.max_value == '0);

  `KAH_ASSERT_NEXT(a_final_result, step && item.final_byte, m_axis_tvalid, "result lost")
  `KAH_ASSERT_NEXT(a_byte_held, item_valid && !advance, item_valid, "byte dropped in stall")
  `KAH_ASSERT_NOW(a_to_zero_unfound, m_axis_tvalid, to_clean, "stray timeout value")
  `KAH_ASSERT_NOW(a_max_zero_unfound, m_axis_tvalid, max_clean, "stray max value")

endmodule

[hdl/kah_in_reg.sv]
// input register of the keep-alive header parser
module kah_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 advance,
  output logic                 item_valid,
  output kah_pkg::in_item_t    item
);
  import kah_pkg::*;

  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.header_byte <= s_axis_tdata;
      item.final_byte  <= s_axis_tlast;
    end
  end

endmodule

[hdl/kah_parser.sv]
// directive parser: phase machine, value accumulators and result formation
module kah_parser #(
  parameter int VALUE_BITS = kah_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  kah_pkg::in_item_t item,
  output logic              result_valid,
  output kah_pkg::result_t  result
);
  import kah_pkg::*;

  localparam int WIDE_BITS = VALUE_BITS + 4;

  phase_t                 phase, phase_next;
  logic [KW_POS_BITS-1:0] kw_pos, kw_pos_next;
  logic [VALUE_BITS-1:0]  to_acc, to_acc_next, max_acc, max_acc_next;
  logic                   to_seen, to_seen_next, max_seen, max_seen_next;

  logic [BYTE_BITS-1:0]   b;
  logic                   is_comma, is_digit;
  phase_t                 after_phase;
  logic [3:0]             digit;
  logic [VALUE_BITS-1:0]  grow_src, grown;
  logic [WIDE_BITS-1:0]   wide_src, prod, lim;
  logic [OUT_BITS+VALUE_BITS-1:0] to_ext, max_ext;

  assign b           = item.header_byte;
  assign is_comma    = (b == CH_COMMA);
  assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign after_phase = is_comma ? PH_SKIP_WS : PH_SKIP_COMMA;
  assign digit       = 4'(b - CH_ZERO);

  // shared times-ten-plus-digit unit with saturation
  assign grow_src = (phase == PH_DIGITS_MAX) ? max_acc : to_acc;
  assign wide_src = {4'b0, grow_src};
  assign prod     = (wide_src << 3) + (wide_src << 1) + {{VALUE_BITS{1'b0}}, digit};
  assign lim      = {4'b0, {VALUE_BITS{1'b1}}};
  assign grown    = (prod > lim) ? {VALUE_BITS{1'b1}} : prod[VALUE_BITS-1:0];

  always_comb begin
    phase_next  = phase;
    kw_pos_next = kw_pos;
    unique case (phase)
      PH_SKIP_WS: begin
        if (is_ws(b) || is_comma) begin
          phase_next = PH_SKIP_WS;
        end else if (b == kw_to_char(3'd0)) begin
          phase_next  = PH_MATCH_TO;
          kw_pos_next = 3'd1;
        end else if (b == kw_max_char(3'd0)) begin
          phase_next  = PH_MATCH_MAX;
          kw_pos_next = 3'd1;
        end else begin
          phase_next = PH_SKIP_COMMA;
        end
      end
      PH_MATCH_TO: begin
        if ((kw_pos <= KW_TO_LAST) && (b == kw_to_char(kw_pos))) begin
          kw_pos_next = kw_pos + 3'd1;
          if (kw_pos == KW_TO_LAST) begin
            phase_next = PH_EQ_TO;
          end
        end else begin
          phase_next = after_phase;
        end
      end
      PH_MATCH_MAX: begin
        if ((kw_pos <= KW_MAX_LAST) && (b == kw_max_char(kw_pos))) begin
          kw_pos_next = kw_pos + 3'd1;
          if (kw_pos == KW_MAX_LAST) begin
            phase_next = PH_EQ_MAX;
          end
        end else begin
          phase_next = after_phase;
        end
      end
      PH_EQ_TO: begin
        phase_next = (b == CH_EQ) ? PH_DIGITS_TO : after_phase;
      end
      PH_EQ_MAX: begin
        phase_next = (b == CH_EQ) ? PH_DIGITS_MAX : after_phase;
      end
      PH_DIGITS_TO: begin
        if (!is_digit) begin
          phase_next = after_phase;
        end
      end
      PH_DIGITS_MAX: begin
        if (!is_digit) begin
          phase_next = after_phase;
        end
      end
      PH_SKIP_COMMA: begin
        if (is_comma) begin
          phase_next = PH_SKIP_WS;
        end
      end
      default: begin
        phase_next = PH_SKIP_WS;
      end
    endcase
    if ((phase_next == PH_SKIP_WS) || (phase_next == PH_SKIP_COMMA)) begin
      kw_pos_next = '0;
    end
  end

  always_comb begin
    to_acc_next   = to_acc;
    to_seen_next  = to_seen;
    max_acc_next  = max_acc;
    max_seen_next = max_seen;
    unique case (phase)
      PH_EQ_TO: begin
        if (b == CH_EQ) begin
          to_acc_next  = '0;
          to_seen_next = 1'b1;
        end
      end
      PH_EQ_MAX: begin
        if (b == CH_EQ) begin
          max_acc_next  = '0;
          max_seen_next = 1'b1;
        end
      end
      PH_DIGITS_TO: begin
        if (is_digit) begin
          to_acc_next = grown;
        end
      end
      PH_DIGITS_MAX: begin
        if (is_digit) begin
          max_acc_next = grown;
        end
      end
      default: begin
      end
    endcase
  end

  assign to_ext  = {{OUT_BITS{1'b0}}, to_acc_next};
  assign max_ext = {{OUT_BITS{1'b0}}, max_acc_next};

  always_comb begin
    result_valid         = step && item.final_byte;
    result.timeout_found = to_seen_next;
    result.timeout_value = to_seen_next ? to_ext[OUT_BITS-1:0] : '0;
    result.max_found     = max_seen_next;
    result.max_value     = max_seen_next ? max_ext[OUT_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SKIP_WS;
      kw_pos   <= '0;
      to_acc   <= '0;
      to_seen  <= 1'b0;
      max_acc  <= '0;
      max_seen <= 1'b0;
    end else if (step) begin
      if (item.final_byte) begin
        phase    <= PH_SKIP_WS;
        kw_pos   <= '0;
        to_acc   <= '0;
        to_seen  <= 1'b0;
        max_acc  <= '0;
        max_seen <= 1'b0;
      end else begin
        phase    <= phase_next;
        kw_pos   <= kw_pos_next;
        to_acc   <= to_acc_next;
        to_seen  <= to_seen_next;
        max_acc  <= max_acc_next;
        max_seen <= max_seen_next;
      end
    end
  end

endmodule
